FILE: hw/rtl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// shared types and constants for the utf-8 stream validator
// ----------------------------------------------------------------------------
package u8sv_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  // continuation byte test: 10xxxxxx
  localparam logic [1:0] CONT_TAG = 2'b10;

  // value range limits
  localparam logic [CP_W-1:0] MIN_2B    = 21'h00_0080;
  localparam logic [CP_W-1:0] MIN_3B    = 21'h00_0800;
  localparam logic [CP_W-1:0] MIN_4B    = 21'h01_0000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10_FFFF;
  localparam logic [9:0]      SURR_HI   = 10'h1B;

  // sequence lengths
  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             seq_ok;
    logic             buffer_done;
    logic             buffer_ok;
  } out_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  accum;
    logic [1:0]       bytes_left;
    logic [LEN_W-1:0] seq_total;
    logic             seq_fault;
    logic             buffer_fault;
  } dec_state_t;

endpackage

FILE: hw/rtl/u8sv_step.sv
// ----------------------------------------------------------------------------
// u8sv_step
// one byte of decode: lead classification, payload gather, range checks
// ----------------------------------------------------------------------------
module u8sv_step
  import u8sv_pkg::*;
(
  input  dec_state_t st,
  input  in_item_t   item,
  output dec_state_t st_nxt,
  output logic       emit,
  output out_item_t  res
);

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_STRAY
  } lead_cls_t;

  function automatic logic value_ok(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len);
    logic ok;
    begin
      case (len)
        LEN_2:   ok = (cp >= MIN_2B);
        LEN_3:   ok = (cp >= MIN_3B) && (cp[CP_W-1:11] != SURR_HI);
        LEN_4:   ok = (cp >= MIN_4B) && (cp <= MAX_CP);
        default: ok = 1'b1;
      endcase
      return ok;
    end
  endfunction

  lead_cls_t        cls;
  logic [CP_W-1:0]  acc_shift;
  logic [1:0]       bl_dec;
  logic             fault_new;
  logic             trunc;
  logic             r_ok;
  logic [LEN_W-1:0] r_len;
  logic [CP_W-1:0]  r_cp;
  logic             last;

  assign last      = item.end_of_buffer;
  assign acc_shift = {st.accum[CP_W-7:0], item.data_byte[5:0]};
  assign bl_dec    = st.bytes_left - 2'd1;
  assign fault_new = st.seq_fault | (item.data_byte[7:6] != CONT_TAG);

  always_comb begin
    unique case (item.data_byte) inside
      [8'h00:8'h7F]: cls = CLS_ASCII;
      [8'hC0:8'hDF]: cls = CLS_LEAD2;
      [8'hE0:8'hEF]: cls = CLS_LEAD3;
      [8'hF0:8'hF7]: cls = CLS_LEAD4;
      default:       cls = CLS_STRAY;
    endcase
  end

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    trunc  = 1'b0;
    r_ok   = 1'b0;
    r_len  = LEN_1;
    r_cp   = {13'd0, item.data_byte};

    if (st.bytes_left == 2'd0) begin
      unique case (cls) inside
        CLS_ASCII: begin
          emit = 1'b1;
          r_ok = 1'b1;
        end
        CLS_STRAY: begin
          emit = 1'b1;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          st_nxt.seq_fault = 1'b0;
          if (cls == CLS_LEAD2) begin
            st_nxt.accum      = {16'd0, item.data_byte[4:0]};
            st_nxt.bytes_left = 2'd1;
            st_nxt.seq_total  = LEN_2;
          end else if (cls == CLS_LEAD3) begin
            st_nxt.accum      = {17'd0, item.data_byte[3:0]};
            st_nxt.bytes_left = 2'd2;
            st_nxt.seq_total  = LEN_3;
          end else begin
            st_nxt.accum      = {18'd0, item.data_byte[2:0]};
            st_nxt.bytes_left = 2'd3;
            st_nxt.seq_total  = LEN_4;
          end
          // buffer ends right after the lead byte
          if (last) begin
            emit  = 1'b1;
            trunc = 1'b1;
            r_cp  = st_nxt.accum;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end else begin
      st_nxt.accum      = acc_shift;
      st_nxt.bytes_left = bl_dec;
      st_nxt.seq_fault  = fault_new;
      r_cp              = acc_shift;
      if (bl_dec == 2'd0) begin
        emit             = 1'b1;
        r_len            = st.seq_total;
        r_ok             = !fault_new && value_ok(acc_shift, st.seq_total);
        st_nxt.accum     = '0;
        st_nxt.seq_total = '0;
        st_nxt.seq_fault = 1'b0;
      end else if (last) begin
        emit  = 1'b1;
        trunc = 1'b1;
        r_len = st.seq_total - {1'b0, bl_dec};
      end
    end

    if (trunc) begin
      r_len  = (st.bytes_left == 2'd0) ? LEN_1 : r_len;
      r_ok   = 1'b0;
      st_nxt = '0;
    end else if (emit) begin
      if (last) begin
        st_nxt.buffer_fault = 1'b0;
      end else if (!r_ok) begin
        st_nxt.buffer_fault = 1'b1;
      end
    end

    res.code_point  = r_cp;
    res.seq_length  = r_len;
    res.seq_ok      = r_ok;
    res.buffer_done = last;
    res.buffer_ok   = r_ok && !st.buffer_fault;
  end

endmodule

FILE: hw/rtl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// byte-wide utf-8 decoder with per-sequence and per-buffer verdicts
// ----------------------------------------------------------------------------
//
//  channel  ports                        direction  transaction
//  -------  ---------------------------  ---------  --------------------------
//  in       in_valid in_stall in_data    sink       one byte + end of buffer
//  out      out_valid out_stall out_data source     one decoded sequence
//
//  one byte per clock sustained while out_stall is low; a byte is held in the
//  input register, decoded from there, and its result is registered in the
//  result register that drives out_data
//  throughput is set by the single decode stage, which holds the sequence state
//  synchronous active-low reset clears both stage valids and the decode state
//  out_stall holds the result register; bytes that close nothing keep flowing,
//  a byte that needs the result register waits in the input register
//
module utf8_stream_validator
  import u8sv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,

  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,

  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register
  logic       s1_valid_r;
  in_item_t   s1_item_r;

  // decode state and result register
  dec_state_t state_r;
  dec_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;

  logic       step_emit;
  out_item_t  step_res;
  logic       out_free;
  logic       proc;

  u8sv_step u_step (
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .emit   (step_emit),
    .res    (step_res)
  );

  // result register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // the byte in the input register is decoded this cycle; if it makes a
  // result it must have room in the result register
  assign proc = s1_valid_r && (!step_emit || out_free);

  // input register refills when empty or draining
  assign in_stall = s1_valid_r && !proc;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (proc) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
    if (proc && step_emit) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a buffer verdict can only be good when the sequence itself is good
  a_bok_implies_sok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.seq_ok || !out_data_r.buffer_ok))
    else $error("buffer_ok set on an invalid sequence");

  // a pending sequence always declares more bytes than are still due
  a_seq_total_sane : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_left != 2'd0) |-> (state_r.seq_total > {1'b0, state_r.bytes_left}))
    else $error("sequence length inconsistent with bytes left");

  // every emitted length is between one and four
  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.seq_length >= LEN_1 && out_data_r.seq_length <= LEN_4))
    else $error("sequence length out of range");

  // closing a buffer restarts the buffer verdict
  a_buffer_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (proc && step_emit && step_res.buffer_done) |=> !state_r.buffer_fault)
    else $error("buffer fault survived the end of buffer");

endmodule

FILE: test/tb_utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator
// self-checking testbench for the byte-wide utf-8 stream validator
//
// bytes go in one transaction at a time, with end-of-buffer flags. A local
// decoder model predicts each decoded sequence and verdict. Every result
// transaction is checked, field by field, against the oldest prediction.
// Stimulus is a short directed set, then random well-formed buffers, buffers
// with broken sequences, and raw byte noise. Both sides insert random gaps
// and stalls.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator
  import u8sv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // kinds of damage a random sequence may carry
  typedef enum int {
    FLAW_NONE,
    FLAW_OVERLONG,
    FLAW_SURROGATE,
    FLAW_TOO_BIG,
    FLAW_BAD_CONT,
    FLAW_STRAY,
    FLAW_TRUNCATED
  } flaw_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // decoder model state, mirrors the block's sequence and buffer tracking
  dec_state_t dec;

  // decoded sequences predicted but not yet seen at the output
  out_item_t pending_seqs[$];

  int  bytes_sent;
  int  results_seen;
  int  miscompares;

  // pacing switches, flipped now and then so runs with and without gaps mix
  bit  in_gaps_on;
  bit  out_stalls_on;

  utf8_stream_validator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------

  // range checks on a finished sequence: overlong, surrogate, above max
  function automatic logic scalar_ok(input logic [CP_W-1:0] cp,
                                     input logic [LEN_W-1:0] len);
    case (len)
      LEN_2:   return cp >= MIN_2B;
      LEN_3:   return (cp >= MIN_3B) && (cp[CP_W-1:11] != SURR_HI);
      LEN_4:   return (cp >= MIN_4B) && (cp <= MAX_CP);
      default: return 1'b1;
    endcase
  endfunction

  // builds one result and updates the sticky buffer verdict
  function automatic out_item_t close_seq(input logic [CP_W-1:0] cp,
                                          input logic [LEN_W-1:0] len,
                                          input logic ok,
                                          input logic done);
    out_item_t r;
    r.code_point  = cp;
    r.seq_length  = len;
    r.seq_ok      = ok;
    r.buffer_done = done;
    r.buffer_ok   = ok && !dec.buffer_fault;
    if (done) begin
      dec.buffer_fault = 1'b0;
    end else if (!ok) begin
      dec.buffer_fault = 1'b1;
    end
    return r;
  endfunction

  // advances the model by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    logic [7:0]       b;
    logic             last;
    logic [LEN_W-1:0] used;
    b    = it.data_byte;
    last = it.end_of_buffer;
    res  = '0;
    if (dec.bytes_left == 2'd0) begin
      if (!b[7]) begin
        res = close_seq(CP_W'(b), LEN_1, 1'b1, last);
        return 1'b1;
      end
      if (b[7:5] == 3'b110) begin
        dec.accum      = CP_W'(b[4:0]);
        dec.bytes_left = 2'd1;
        dec.seq_total  = LEN_2;
      end else if (b[7:4] == 4'b1110) begin
        dec.accum      = CP_W'(b[3:0]);
        dec.bytes_left = 2'd2;
        dec.seq_total  = LEN_3;
      end else if (b[7:3] == 5'b11110) begin
        dec.accum      = CP_W'(b[2:0]);
        dec.bytes_left = 2'd3;
        dec.seq_total  = LEN_4;
      end else begin
        // stray continuation byte or f8-ff where a lead belongs
        res = close_seq(CP_W'(b), LEN_1, 1'b0, last);
        return 1'b1;
      end
      dec.seq_fault = 1'b0;
    end else begin
      // a bad continuation byte still gets folded into the payload
      if (b[7:6] != CONT_TAG) begin
        dec.seq_fault = 1'b1;
      end
      dec.accum      = {dec.accum[CP_W-7:0], b[5:0]};
      dec.bytes_left = dec.bytes_left - 2'd1;
      if (dec.bytes_left == 2'd0) begin
        res = close_seq(dec.accum, dec.seq_total,
                        !dec.seq_fault && scalar_ok(dec.accum, dec.seq_total), last);
        dec.accum     = '0;
        dec.seq_total = '0;
        dec.seq_fault = 1'b0;
        return 1'b1;
      end
    end
    // buffer ended inside a sequence: report the partial value, start over
    if (last) begin
      used             = dec.seq_total - LEN_W'(dec.bytes_left);
      dec.buffer_fault = 1'b1;
      res              = close_seq(dec.accum, used, 1'b0, 1'b1);
      dec              = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one byte transaction; called and returns at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int        gap;
    out_item_t res;
    gap = in_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_buffer: eob};
    // stall is settled by the falling edge and holds until the next rise
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    if (decode_byte('{data_byte: b, end_of_buffer: eob}, res)) begin
      pending_seqs = {pending_seqs, res};
    end
  endtask

  // encodes cp in len bytes (longer than needed gives an overlong form),
  // sends the first nsend of them and may damage one continuation byte
  task automatic send_scalar(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                             input int nsend, input int bad_at, input logic eob);
    logic [7:0] seq [4];
    seq = '{default: 8'h00};
    case (len)
      LEN_1: seq[0] = {1'b0, cp[6:0]};
      LEN_2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {CONT_TAG, cp[5:0]};
      end
      LEN_3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {CONT_TAG, cp[11:6]};
        seq[2] = {CONT_TAG, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {CONT_TAG, cp[17:12]};
        seq[2] = {CONT_TAG, cp[11:6]};
        seq[3] = {CONT_TAG, cp[5:0]};
      end
    endcase
    if (bad_at > 0) begin
      seq[bad_at][5:0] = 6'($urandom);
      do seq[bad_at][7:6] = 2'($urandom); while (seq[bad_at][7:6] == CONT_TAG);
    end
    for (int i = 0; i < nsend; i++) begin
      send_byte(seq[i], eob && (i == nsend - 1));
    end
  endtask

  // a legal scalar value for the given encoded length
  function automatic logic [CP_W-1:0] pick_scalar(input logic [LEN_W-1:0] len);
    logic [CP_W-1:0] c;
    case (len)
      LEN_1: c = CP_W'($urandom_range(0, MIN_2B - 1));
      LEN_2: c = CP_W'($urandom_range(MIN_2B, MIN_3B - 1));
      LEN_3: begin
        do c = CP_W'($urandom_range(MIN_3B, MIN_4B - 1));
        while (c[CP_W-1:11] == SURR_HI);
      end
      default: c = CP_W'($urandom_range(MIN_4B, MAX_CP));
    endcase
    return c;
  endfunction

  task automatic shuffle_pacing();
    if ($urandom_range(0, 7) == 0) in_gaps_on = !in_gaps_on;
    if ($urandom_range(0, 7) == 0) out_stalls_on = !out_stalls_on;
  endtask

  // one buffer of nseq sequences; each is damaged with the given chance
  task automatic send_buffer(input int nseq, input int flaw_pct);
    flaw_t            flaw;
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  cp;
    logic             last;
    for (int s = 0; s < nseq; s++) begin
      last = (s == nseq - 1);
      flaw = ($urandom_range(1, 100) <= flaw_pct) ?
             flaw_t'($urandom_range(FLAW_OVERLONG, FLAW_TRUNCATED)) : FLAW_NONE;
      len  = LEN_W'($urandom_range(LEN_2, LEN_4));
      case (flaw)
        FLAW_OVERLONG: begin
          case (len)
            LEN_2:   cp = CP_W'($urandom_range(0, MIN_2B - 1));
            LEN_3:   cp = CP_W'($urandom_range(0, MIN_3B - 1));
            default: cp = CP_W'($urandom_range(0, MIN_4B - 1));
          endcase
          send_scalar(cp, len, int'(len), 0, last);
        end
        FLAW_SURROGATE: begin
          cp = CP_W'($urandom_range('hD800, 'hDFFF));
          send_scalar(cp, LEN_3, 3, 0, last);
        end
        FLAW_TOO_BIG: begin
          cp = CP_W'($urandom_range(MAX_CP + 1, 'h1F_FFFF));
          send_scalar(cp, LEN_4, 4, 0, last);
        end
        FLAW_BAD_CONT: begin
          send_scalar(pick_scalar(len), len, int'(len),
                      int'($urandom_range(1, len - 1)), last);
        end
        FLAW_STRAY: begin
          if ($urandom_range(0, 1)) begin
            send_byte(8'($urandom_range('h80, 'hBF)), last);
          end else begin
            send_byte(8'($urandom_range('hF8, 'hFF)), last);
          end
        end
        FLAW_TRUNCATED: begin
          // buffer ends early, so this sequence closes it
          send_scalar(pick_scalar(len), len, int'($urandom_range(1, len - 1)), 0, 1'b1);
          break;
        end
        default: begin
          len = LEN_W'($urandom_range(LEN_1, LEN_4));
          send_scalar(pick_scalar(len), len, int'(len), 0, last);
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // hand-picked bytes: field extremes and each rejection rule
  task automatic test_directed();
    logic [7:0] dir_bytes [26] = '{
      8'h00, 8'h7F,                 // ascii extremes, buffer closes on a good one
      8'hC2, 8'h80,                 // smallest legal two-byte value
      8'hC1, 8'hBF,                 // two-byte overlong
      8'hED, 8'hA0, 8'h80,          // surrogate
      8'hF4, 8'h90, 8'h80, 8'h80,   // just above the top code point
      8'hE0, 8'h80, 8'h80,          // three-byte overlong
      8'h80, 8'hFF,                 // stray bytes where a lead belongs
      8'hC3, 8'h41,                 // bad continuation, still consumed
      8'hF0, 8'h9F,                 // buffer ends mid-sequence
      8'hF7, 8'hBF, 8'hBF, 8'hBF    // all payload bits set, closes buffer
    };
    logic dir_eob [26] = '{
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
    };
    for (int i = 0; i < 26; i++) begin
      send_byte(dir_bytes[i], dir_eob[i]);
    end
  endtask

  // mostly clean text, with a rare damaged sequence
  task automatic test_well_formed_buffers();
    int stop_at;
    stop_at = bytes_sent + 600;
    while (bytes_sent < stop_at) begin
      shuffle_pacing();
      send_buffer($urandom_range(1, 16), 5);
    end
  endtask

  // half of all sequences carry one of the flaw kinds
  task automatic test_malformed_buffers();
    int stop_at;
    stop_at = bytes_sent + 300;
    while (bytes_sent < stop_at) begin
      shuffle_pacing();
      send_buffer($urandom_range(1, 8), 50);
    end
  endtask

  // unstructured bytes with random buffer ends
  task automatic test_noise();
    int stop_at;
    stop_at = bytes_sent + 200;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 31) == 0) shuffle_pacing();
      send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall before each transaction, then compare
  // --------------------------------------------------------------------------
  initial begin : result_check
    out_item_t got;
    out_item_t want;
    int        pause;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      pause = out_stalls_on ? $urandom_range(0, 16) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      // sample mid-cycle; the transaction happens at the next rising edge
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      got = out_data;
      @(posedge clk);
      results_seen++;
      if (pending_seqs.size() == 0) begin
        miscompares++;
        if (miscompares <= 10) begin
          $display("result %0d: unexpected, cp %h len %0d ok %b done %b buf_ok %b",
                   results_seen, got.code_point, got.seq_length, got.seq_ok,
                   got.buffer_done, got.buffer_ok);
        end
      end else begin
        want = pending_seqs.pop_front();
        if (got !== want) begin
          miscompares++;
          if (miscompares <= 10) begin
            $display("result %0d: cp %h/%h len %0d/%0d ok %b/%b done %b/%b buf_ok %b/%b",
                     results_seen, want.code_point, got.code_point,
                     want.seq_length, got.seq_length, want.seq_ok, got.seq_ok,
                     want.buffer_done, got.buffer_done, want.buffer_ok, got.buffer_ok);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    dec            = '0;
    bytes_sent     = 0;
    results_seen   = 0;
    miscompares    = 0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_well_formed_buffers();
    test_malformed_buffers();
    test_noise();
    in_valid <= 1'b0;

    // drain, then give the pipeline time to show any extra result
    while (pending_seqs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (miscompares == 0 && pending_seqs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
